### rtl/rel_pkg.sv
// Shared types, widths and codes of the repulsive embedding loss block.
package rel_pkg;

	localparam int MAX_MASKS_DEF = 16;
	localparam int EMBED_DIM_DEF = 16;

	localparam int MASK_COUNT_W = 5;
	localparam int INV_W        = 17;
	localparam int CFG_W        = 17;
	localparam int VALUE_W      = 16;
	localparam int SQ_W         = 32;
	localparam int SUM_W        = 44;
	localparam int SUM_HALF_W   = 22;
	localparam int PROD_W       = SUM_HALF_W + INV_W;
	localparam int LOSS_W       = 40;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	localparam logic REG_MASK_COUNT     = 1'b0;
	localparam logic REG_INVERSE_OTHERS = 1'b1;

	localparam logic [MASK_COUNT_W-1:0] MASK_COUNT_RST = 5'd2;
	localparam logic [INV_W-1:0]        INVERSE_RST    = 17'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_EMIT
	} rel_state_t;

	typedef struct packed {
		logic wr;
		logic capture;
		logic rd;
		logic step;
		logic mul_lo;
		logic mul_hi;
		logic emit;
	} rel_cmd_t;

endpackage

### rtl/repulsive_embedding_loss.sv
// Repulsive embedding loss: one pixel's push term over all other mask means.
// A load item is written in the cycle it is accepted. A pixel component is accepted,
// then walks the A = min(mask_count, MAX_MASKS) active masks, one mask per cycle, through
// the single mean-store read port and square-accumulate unit, and then drains that
// pipeline through DRAIN1 and DRAIN2; a component outside EMBED_DIM, or any component while no mask
// is active, skips the walk and the drain. The final component then passes through two half-width
// multiplies and the output load, and a further wait while a previous result is
// still held in the output register.
// The mean store has no reset; every mean must be loaded before a pixel uses it.
module repulsive_embedding_loss
	import rel_pkg::*;
#(
	parameter int MAX_MASKS = MAX_MASKS_DEF,
	parameter int EMBED_DIM = EMBED_DIM_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic [3:0]                mask_index,
	input  logic [3:0]                component,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [LOSS_W-1:0]         loss,
	output logic                      saturated
);

	logic [MASK_COUNT_W-1:0] mask_count_q;
	logic [INV_W-1:0]        inverse_q;
	rel_cmd_t                cmd;
	logic                    out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_count_q <= MASK_COUNT_RST;
			inverse_q    <= INVERSE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MASK_COUNT:     mask_count_q <= cfg_data[MASK_COUNT_W-1:0];
				REG_INVERSE_OTHERS: inverse_q    <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	rel_ctrl #(
		.MAX_MASKS(MAX_MASKS),
		.EMBED_DIM(EMBED_DIM)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.mask_index (mask_index),
		.component  (component),
		.last       (last),
		.mask_count (mask_count_q),
		.out_free   (out_free),
		.cmd        (cmd)
	);

	rel_dpath #(
		.MAX_MASKS(MAX_MASKS),
		.EMBED_DIM(EMBED_DIM)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.mask_index     (mask_index),
		.component      (component),
		.value          (value),
		.inverse_others (inverse_q),
		.out_ready      (out_ready),
		.out_free       (out_free),
		.out_valid      (out_valid),
		.loss           (loss),
		.saturated      (saturated)
	);

endmodule

### rtl/rel_ctrl.sv
// Controller: sequences loads, the walk over other masks, and the final scaling.
module rel_ctrl
	import rel_pkg::*;
#(
	parameter int MAX_MASKS = MAX_MASKS_DEF,
	parameter int EMBED_DIM = EMBED_DIM_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    action,
	input  logic [3:0]              mask_index,
	input  logic [3:0]              component,
	input  logic                    last,
	input  logic [MASK_COUNT_W-1:0] mask_count,
	input  logic                    out_free,
	output rel_cmd_t                cmd
);

	localparam int CNT_W = $clog2(MAX_MASKS + 1);
	localparam int CMP_W = (CNT_W > MASK_COUNT_W) ? CNT_W : MASK_COUNT_W;
	localparam logic [CMP_W-1:0] MAXM = CMP_W'(MAX_MASKS);

	rel_state_t       state_q, state_d;
	logic [CNT_W-1:0] j_q;
	logic [3:0]       owner_q;
	logic             last_q;

	logic [CMP_W-1:0] mc_ext, active_w;
	logic             last_j, skip, comp_ok, mask_ok, accept;

	assign mc_ext   = CMP_W'(mask_count);
	assign active_w = (mc_ext > MAXM) ? MAXM : mc_ext;
	assign last_j   = (CMP_W'(j_q) + CMP_W'(1)) == active_w;
	assign skip     = CMP_W'(j_q) == CMP_W'(owner_q);
	assign comp_ok  = 9'(component) < 9'(EMBED_DIM);
	assign mask_ok  = 9'(mask_index) < 9'(MAX_MASKS);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			owner_q <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && action == ACT_PIXEL) begin
				owner_q <= mask_index;
				last_q  <= last;
				j_q     <= '0;
			end else if (state_q == ST_WALK) begin
				j_q <= j_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_PIXEL) begin
					if (comp_ok && active_w != '0)
						state_d = ST_WALK;
					else if (last)
						state_d = ST_MUL_LO;
				end
			end
			ST_WALK: begin
				if (last_j)
					state_d = ST_DRAIN1;
			end
			ST_DRAIN1: state_d = ST_DRAIN2;
			ST_DRAIN2: state_d = last_q ? ST_MUL_LO : ST_IDLE;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.wr      = in_valid && action == ACT_LOAD && comp_ok && mask_ok;
				cmd.capture = in_valid && action == ACT_PIXEL;
			end
			ST_WALK: begin
				// The owning mask is stepped over but issues no read.
				cmd.rd   = !skip;
				cmd.step = 1'b1;
			end
			ST_MUL_LO: cmd.mul_lo = 1'b1;
			ST_MUL_HI: cmd.mul_hi = 1'b1;
			ST_EMIT:   cmd.emit   = out_free;
			default: ;
		endcase
	end

endmodule

### rtl/rel_dpath.sv
// Datapath: mean store, square-accumulate pipeline, scaling and output register.
module rel_dpath
	import rel_pkg::*;
#(
	parameter int MAX_MASKS = MAX_MASKS_DEF,
	parameter int EMBED_DIM = EMBED_DIM_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rel_cmd_t                  cmd,
	input  logic [3:0]                mask_index,
	input  logic [3:0]                component,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [INV_W-1:0]          inverse_others,
	input  logic                      out_ready,
	output logic                      out_free,
	output logic                      out_valid,
	output logic [LOSS_W-1:0]         loss,
	output logic                      saturated
);

	localparam int DEPTH  = MAX_MASKS * EMBED_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

	logic [VALUE_W-1:0] mem [DEPTH];

	logic [ADDR_W-1:0]  waddr, addr_q;
	logic [VALUE_W-1:0] val_q;
	logic [VALUE_W-1:0] rdata_s1;
	logic               vld_s1, vld_s2;
	logic [SQ_W-1:0]    sq_s2;
	logic [SUM_W-1:0]   sum_q;
	logic               clip_q;
	logic [PROD_W-1:0]  p_lo_q, p_hi_q;
	logic [LOSS_W-1:0]  loss_q;
	logic               sat_q, out_valid_q;

	logic signed [VALUE_W:0]   diff;
	logic signed [2*VALUE_W+1:0] sq_full;
	logic [SUM_W:0]            sum_next;
	logic [61:0]               rnd;
	logic [44:0]               scaled;
	logic                      over;

	assign waddr = ADDR_W'(32'(mask_index) * EMBED_DIM + 32'(component));

	always_ff @(posedge clk) begin
		if (cmd.wr)
			mem[waddr] <= value;
		if (cmd.rd)
			rdata_s1 <= mem[addr_q];
	end

	// Squared difference to one other mask's mean, one mask per cycle.
	assign diff    = $signed({val_q[VALUE_W-1], val_q}) -
	                 $signed({rdata_s1[VALUE_W-1], rdata_s1});
	assign sq_full = diff * diff;
	assign sum_next = {1'b0, sum_q} + (SUM_W + 1)'(sq_s2);

	// Full product is p_hi * 2^22 + p_lo; round half up, then halve via the shift.
	assign rnd    = {1'b0, p_hi_q, 22'b0} + 62'(p_lo_q) + 62'(1 << 16);
	assign scaled = rnd[61:17];
	assign over   = |scaled[44:LOSS_W];

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			val_q  <= value;
			addr_q <= ADDR_W'(component);
		end else if (cmd.step) begin
			addr_q <= addr_q + ADDR_W'(EMBED_DIM);
		end
		if (vld_s1)
			sq_s2 <= sq_full[SQ_W-1:0];
		if (cmd.mul_lo)
			p_lo_q <= sum_q[SUM_HALF_W-1:0] * inverse_others;
		if (cmd.mul_hi)
			p_hi_q <= sum_q[SUM_W-1:SUM_HALF_W] * inverse_others;
		if (cmd.emit) begin
			loss_q <= over ? LOSS_MAX : scaled[LOSS_W-1:0];
			sat_q  <= over || clip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			sum_q       <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd;
			vld_s2 <= vld_s1;
			if (cmd.emit) begin
				sum_q  <= '0;
				clip_q <= 1'b0;
			end else if (vld_s2) begin
				if (sum_next[SUM_W]) begin
					sum_q  <= SUM_MAX;
					clip_q <= 1'b1;
				end else begin
					sum_q <= sum_next[SUM_W-1:0];
				end
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign loss      = loss_q;
	assign saturated = sat_q;

endmodule

### rtl/rel_chk.sv
// Port-level checker for the repulsive embedding loss block, bound to the top level.
module rel_chk
	import rel_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              action,
	input logic              out_valid,
	input logic              out_ready,
	input logic [LOSS_W-1:0] loss,
	input logic              saturated
);

	// A held result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(loss) && $stable(saturated))
		else $error("result changed while stalled");

	// A result appears only after the block has stopped taking items to compute it.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the block was accepting items");

	// A mean load completes in the cycle it is accepted.
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_LOAD |=> in_ready)
		else $error("block busy after a load item");

endmodule

bind repulsive_embedding_loss rel_chk u_rel_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.action    (action),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.loss      (loss),
	.saturated (saturated)
);

### tb/rel_loss_checker.sv
`timescale 1ns / 100ps
// Checker that mirrors the repulsive embedding loss block and compares every loss it emits.
module rel_loss_checker
	import rel_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      action,
	input  logic [3:0]                mask_index,
	input  logic [3:0]                component,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      last,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [LOSS_W-1:0]         loss,
	input  logic                      saturated,
	output int                        errors,
	output int                        pending
);

	typedef struct packed {
		logic [LOSS_W-1:0] loss;
		logic              clipped;
	} pixel_loss_t;

	localparam logic [SUM_W-1:0]  SUM_TOP  = '1;
	localparam logic [LOSS_W-1:0] LOSS_TOP = '1;

	logic [VALUE_W-1:0]      mean_copy [MAX_MASKS_DEF*EMBED_DIM_DEF];
	logic [SUM_W-1:0]        push_sum;
	logic                    push_clipped;
	logic [MASK_COUNT_W-1:0] mask_count_q;
	logic [INV_W-1:0]        inv_others;
	pixel_loss_t             expected_losses[$];
	pixel_loss_t             want;

	// Adds the squared distance from one pixel component to every other active mask mean.
	task automatic accumulate_component(input logic [3:0] owner, input logic [3:0] comp,
			input logic signed [VALUE_W-1:0] v);
		int                    active;
		logic signed [VALUE_W:0] diff;
		logic [SQ_W-1:0]       sq;
		logic [SUM_W:0]        total;
		active = (mask_count_q > MAX_MASKS_DEF) ? MAX_MASKS_DEF : int'(mask_count_q);
		for (int j = 0; j < active; j++) begin
			if (j != owner) begin
				diff = v - $signed(mean_copy[j*EMBED_DIM_DEF + comp]);
				sq = diff * diff;
				total = {1'b0, push_sum} + sq;
				if (total > {1'b0, SUM_TOP}) begin
					push_sum = SUM_TOP;
					push_clipped = 1'b1;
				end else begin
					push_sum = total[SUM_W-1:0];
				end
			end
		end
	endtask

	// Scales the sum by the reciprocal, halves it with rounding, and clips to the output range.
	function automatic pixel_loss_t close_pixel();
		logic [63:0] prod;
		logic [63:0] rounded;
		pixel_loss_t res;
		prod = 64'(push_sum) * 64'(inv_others);
		rounded = (prod + 64'd65536) >> 17;
		res.clipped = push_clipped;
		if (rounded > 64'(LOSS_TOP)) begin
			res.loss = LOSS_TOP;
			res.clipped = 1'b1;
		end else begin
			res.loss = rounded[LOSS_W-1:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_sum = '0;
			push_clipped = 1'b0;
			mask_count_q = MASK_COUNT_RST;
			inv_others = INVERSE_RST;
			expected_losses.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MASK_COUNT)
					mask_count_q = cfg_data[MASK_COUNT_W-1:0];
				else
					inv_others = cfg_data[INV_W-1:0];
			end
			if (in_valid && in_ready) begin
				if (action == ACT_LOAD) begin
					mean_copy[{mask_index, component}] = value;
				end else begin
					accumulate_component(mask_index, component, value);
					if (last) begin
						expected_losses.push_back(close_pixel());
						push_sum = '0;
						push_clipped = 1'b0;
					end
				end
			end
			if (out_valid && out_ready) begin
				if (expected_losses.size() == 0) begin
					$error("loss: no pixel pending, got %0d", loss);
					errors++;
				end else begin
					want = expected_losses.pop_front();
					if (loss !== want.loss) begin
						$error("loss: expected %0d, got %0d", want.loss, loss);
						errors++;
					end
					if (saturated !== want.clipped) begin
						$error("saturated: expected %0b, got %0b", want.clipped, saturated);
						errors++;
					end
				end
			end
			pending <= expected_losses.size();
		end
	end

endmodule

### tb/tb_repulsive_embedding_loss.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, mean and pixel stimulus, and the verdict for the loss block.
module tb_repulsive_embedding_loss;
	import rel_pkg::*;

	localparam int CYCLE_LIMIT   = 800000;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 400;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic                      cfg_index = REG_MASK_COUNT;
	logic [CFG_W-1:0]          cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      action = ACT_LOAD;
	logic [3:0]                mask_index = '0;
	logic [3:0]                component = '0;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      last = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [LOSS_W-1:0]         loss;
	logic                      saturated;

	int                        fail_count;
	int                        pending_losses;
	int                        cycle_count = 0;
	int                        items_sent = 0;
	int                        hold_asks = 0;
	int                        hold_served = 0;
	int                        hold_left = 0;
	bit                        tx_idle_en = 1'b1;
	bit                        rx_idle_en = 1'b1;
	logic [MASK_COUNT_W-1:0]   cur_masks = MASK_COUNT_RST;

	repulsive_embedding_loss dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.mask_index (mask_index),
		.component  (component),
		.value      (value),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.loss       (loss),
		.saturated  (saturated)
	);

	rel_loss_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.mask_index (mask_index),
		.component  (component),
		.value      (value),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.loss       (loss),
		.saturated  (saturated),
		.errors     (fail_count),
		.pending    (pending_losses)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asks != hold_served) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end else begin
			out_ready <= rx_idle_en ? ($urandom_range(99) >= 36) : 1'b1;
		end
	end

	task automatic send_item(input logic act, input logic [3:0] msk, input logic [3:0] comp,
			input logic [VALUE_W-1:0] v, input logic lst);
		int gap;
		gap = 0;
		while (tx_idle_en && $urandom_range(99) < 36)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		mask_index <= msk;
		component <= comp;
		value <= v;
		last <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Waits until every loss has arrived, then lets trailing non-final components finish.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_losses != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [MASK_COUNT_W-1:0] masks, input logic [INV_W-1:0] inv);
		cfg_we <= 1'b1;
		cfg_index <= REG_MASK_COUNT;
		cfg_data <= {(CFG_W - MASK_COUNT_W)'($urandom), masks};
		@(posedge clk);
		cfg_index <= REG_INVERSE_OTHERS;
		cfg_data <= inv;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_masks = masks;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(19))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	function automatic logic [3:0] pick_owner();
		int active;
		active = (cur_masks > MAX_MASKS_DEF) ? MAX_MASKS_DEF : int'(cur_masks);
		if (active < 1 || $urandom_range(4) == 0)
			return 4'($urandom);
		return 4'($urandom_range(active - 1));
	endfunction

	task automatic send_pixel(input int ncomp, input bit sequential);
		logic [3:0] owner;
		logic [3:0] first;
		owner = pick_owner();
		first = 4'($urandom);
		for (int k = 0; k < ncomp; k++)
			send_item(ACT_PIXEL, owner, sequential ? 4'(first + k) : 4'($urandom), pick_value(),
				k == ncomp - 1);
	endtask

	// Mostly whole pixels with random content; the rest are mean loads and stray components.
	task automatic run_phase(input int n_items, input int max_len);
		int start;
		int pick;
		start = items_sent;
		while (items_sent - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 15)
				send_item(ACT_LOAD, 4'($urandom), 4'($urandom), pick_value(), 1'($urandom));
			else if (pick < 25)
				send_item(ACT_PIXEL, 4'($urandom), 4'($urandom), pick_value(), 1'($urandom));
			else
				send_pixel($urandom_range(1, ($urandom_range(9) == 0) ? 16 : max_len),
					1'($urandom));
		end
		drain_and_settle();
	endtask

	task automatic long_pixel(input int ncomp);
		for (int k = 0; k < ncomp; k++)
			send_item(ACT_PIXEL, 4'd0, 4'd0, 16'h7FFF, k == ncomp - 1);
	endtask

	initial begin
		logic [MASK_COUNT_W-1:0] masks;
		logic [INV_W-1:0]        inv;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Every mean entry is written before any pixel can read it.
		for (int i = 0; i < MAX_MASKS_DEF * EMBED_DIM_DEF; i++)
			send_item(ACT_LOAD, 4'(i >> 4), 4'(i), pick_value(), 1'b0);

		// Directed items under the reset setting of two masks.
		send_item(ACT_LOAD, 4'd0, 4'd0, 16'h8000, 1'b0);
		send_item(ACT_LOAD, 4'd1, 4'd0, 16'h7FFF, 1'b0);
		send_item(ACT_LOAD, 4'd0, 4'd2, 16'h1234, 1'b0);
		send_item(ACT_LOAD, 4'd1, 4'd2, 16'h1234, 1'b1);
		send_item(ACT_LOAD, 4'd1, 4'd3, 16'h0000, 1'b0);
		send_item(ACT_PIXEL, 4'd1, 4'd0, 16'h7FFF, 1'b1);
		send_item(ACT_PIXEL, 4'd0, 4'd0, 16'h8000, 1'b1);
		send_item(ACT_PIXEL, 4'd0, 4'd2, 16'h1234, 1'b1);
		// A distance of one gives an odd sum, so the halving rounds a tie upward.
		send_item(ACT_PIXEL, 4'd0, 4'd3, 16'h0001, 1'b1);
		// An owner outside the active masks leaves every active mask as an other mask.
		send_item(ACT_PIXEL, 4'd5, 4'd15, pick_value(), 1'b1);
		send_item(ACT_PIXEL, 4'd15, 4'd12, 16'h8000, 1'b0);
		send_item(ACT_PIXEL, 4'd15, 4'd13, 16'h7FFF, 1'b0);
		send_item(ACT_PIXEL, 4'd15, 4'd14, 16'hFFFF, 1'b0);
		send_item(ACT_PIXEL, 4'd15, 4'd15, 16'h0000, 1'b1);
		send_item(ACT_PIXEL, 4'd0, 4'd7, 16'hFFFF, 1'b0);
		send_item(ACT_PIXEL, 4'd0, 4'd8, 16'h0000, 1'b1);
		send_item(ACT_LOAD, 4'd15, 4'd15, 16'h7FFF, 1'b0);
		drain_and_settle();

		set_config(5'd16, 17'd4369);
		run_phase(120, 4);
		// Short pixels while the result side holds off, so the output backs up into the input.
		hold_asks++;
		run_phase(150, 2);
		set_config(5'd31, 17'd65536);
		run_phase(120, 4);
		set_config(5'd0, 17'd65536);
		run_phase(80, 3);
		set_config(5'd1, 17'd0);
		run_phase(80, 3);
		set_config(5'd16, 17'h1FFFF);
		run_phase(60, 4);

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		set_config(5'd8, 17'd9362);
		run_phase(120, 4);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;

		// Means at one extreme and pixels at the other: the first long pixel clips the
		// accumulator, the second only the scaled loss.
		set_config(5'd16, 17'd65536);
		for (int m = 0; m < MAX_MASKS_DEF; m++)
			send_item(ACT_LOAD, 4'(m), 4'd0, 16'h8000, 1'b0);
		long_pixel(300);
		long_pixel(40);
		drain_and_settle();

		repeat (6) begin
			masks = ($urandom_range(3) == 0) ? MASK_COUNT_W'($urandom)
				: MASK_COUNT_W'($urandom_range(2, 16));
			if ($urandom_range(1) == 0 && masks > 1)
				inv = INV_W'(65536 / (masks - 1));
			else
				inv = INV_W'($urandom);
			set_config(masks, inv);
			run_phase(60, 6);
		end

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
